@@ rtl/mcid_pkg.sv @@
// ----------------------------------------------------------------------------
// mcid_pkg: shared types and constants
// Payload structs, lane control struct, channel numbers and CSR indexes for
// the eight-channel integrating debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcid_pkg;

   localparam int COUNT_BITS  = 8;    // per-channel counter width
   localparam int ADC_BITS    = 10;   // converter bits used for the ignition level
   localparam int SAMPLE_BITS = 10;   // width of the ign_sample field
   localparam int THRESH_BITS = 12;   // ignition threshold / level width
   localparam int NUM_CH      = 8;
   localparam int LIMIT_BITS  = 8 * NUM_CH;
   localparam int CSR_IDX_BITS = 2;

   // channel numbers
   localparam int CH_AC_REQ   = 0;
   localparam int CH_AC_PRESS = 1;
   localparam int CH_HEAD     = 2;
   localparam int CH_BRAKE    = 3;
   localparam int CH_CRANK    = 4;
   localparam int CH_CLUTCH   = 5;
   localparam int CH_STEER    = 6;
   localparam int CH_IGN      = 7;

   // mode codes
   localparam logic MODE_SAMPLE   = 1'b0;
   localparam logic MODE_EVALUATE = 1'b1;

   // CSR indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMITS  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEY_ON  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEY_OFF = 2'd2;

   localparam logic [THRESH_BITS-1:0] KEY_ON_RESET  = '1;
   localparam logic [THRESH_BITS-1:0] KEY_OFF_RESET = '0;

   typedef struct packed {
      logic                   mode;
      logic                   ac_request_pin;
      logic                   ac_pressure_pin;
      logic                   head_lamp_pin;
      logic                   brake_pin;
      logic                   crank_pin;
      logic                   clutch_steer_pin;
      logic [SAMPLE_BITS-1:0] ign_sample;
   } req_payload_type;

   typedef struct packed {
      logic ac_request_on;
      logic ac_pressure_on;
      logic head_lamp_on;
      logic brake_on;
      logic crank_on;
      logic clutch_top_on;
      logic steering_on;
      logic ignition_on;
   } rsp_payload_type;

   // per-lane command for one accepted item
   typedef struct packed {
      logic count_en;   // sample item accepted
      logic eval_en;    // evaluate item accepted
      logic up;         // input active
      logic down;       // input inactive
      logic set;        // bypass: force flag high
      logic clr;        // bypass: force flag low
   } lane_ctl_type;

endpackage

`default_nettype wire

@@ rtl/mcid_lane.sv @@
// ----------------------------------------------------------------------------
// mcid_lane: one debounce channel
// Saturating up/down counter plus qualified flag. Shows the flag value that
// follows the current command so the result can be captured in the same edge.
// ----------------------------------------------------------------------------
`default_nettype none

module mcid_lane (
   input  wire                               clock,
   input  wire                               reset,
   input  mcid_pkg::lane_ctl_type            ctl,
   input  wire [mcid_pkg::COUNT_BITS-1:0]    limit,
   output logic                              flag_next
);
   import mcid_pkg::*;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  flag_ff, flag_in;

   always_comb begin
      count_in = count_ff;
      if (ctl.count_en) begin
         if (ctl.up) begin
            if (count_ff < limit) count_in = count_ff + COUNT_BITS'(1);
         end else if (ctl.down) begin
            if (count_ff != '0) count_in = count_ff - COUNT_BITS'(1);
         end
      end
   end

   always_comb begin
      flag_in = flag_ff;
      if (ctl.eval_en) begin
         if (limit != '0) begin
            if (count_ff >= limit)    flag_in = 1'b1;
            else if (count_ff == '0)  flag_in = 1'b0;
         end else if (ctl.set) begin
            flag_in = 1'b1;
         end else if (ctl.clr) begin
            flag_in = 1'b0;
         end
      end
   end

   assign flag_next = flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flag_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         flag_ff  <= flag_in;
      end
   end

   // counters only move on sample items, flags only on evaluate items
   a_flag_hold_on_sample: assert property (@(posedge clock) disable iff (reset)
      ctl.count_en |=> (flag_ff == $past(flag_ff)))
      else $error("flag changed on a sample item");

   a_count_hold_on_eval: assert property (@(posedge clock) disable iff (reset)
      !ctl.count_en |=> (count_ff == $past(count_ff)))
      else $error("count changed without a sample item");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ctl.count_en |=> (count_ff == $past(count_ff)
                     || count_ff == $past(count_ff) + COUNT_BITS'(1)
                     || count_ff == $past(count_ff) - COUNT_BITS'(1)))
      else $error("count moved by more than one");

endmodule

`default_nettype wire

@@ rtl/mcid_merge.sv @@
// ----------------------------------------------------------------------------
// mcid_merge: result assembly and output buffer
// Packs the lane flags into the result item and holds it in an output
// register backed by a one-entry skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcid_merge (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               accept,
   input  wire [mcid_pkg::NUM_CH-1:0]        flags,
   output logic                              in_ready,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output mcid_pkg::rsp_payload_type         rsp_data
);
   import mcid_pkg::*;

   rsp_payload_type merged;
   rsp_payload_type out_data_ff, skid_data_ff;
   logic            out_valid_ff, skid_valid_ff;

   always_comb begin
      merged.ac_request_on  = flags[CH_AC_REQ];
      merged.ac_pressure_on = flags[CH_AC_PRESS];
      merged.head_lamp_on   = flags[CH_HEAD];
      merged.brake_on       = flags[CH_BRAKE];
      merged.crank_on       = flags[CH_CRANK];
      merged.clutch_top_on  = flags[CH_CLUTCH];
      merged.steering_on    = flags[CH_STEER];
      merged.ignition_on    = flags[CH_IGN];
   end

   assign in_ready  = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : merged;
      end
      if (out_valid_ff && !rsp_ready && accept) begin
         skid_data_ff <= merged;
      end
   end

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item while output is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> (!skid_valid_ff && out_valid_ff))
      else $error("skid item not moved to output");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(accept))
      else $error("result appeared without an accepted item");

endmodule

`default_nettype wire

@@ rtl/multi_channel_integrator_debounce_core.sv @@
// ----------------------------------------------------------------------------
// multi_channel_integrator_debounce_core: eight-channel integrating debouncer
//
// Channels: req_* carries one item per tick (mode, six pins, ignition sample).
// rsp_* returns one item per request: the eight qualified flags after the
// update. csr_* writes the limits (index 0) and the key-on / key-off ignition
// thresholds (indexes 1, 2); csr_ready is always high, other indexes are
// dropped. Write CSRs only while no item is in flight.
// Mode 0 (sample) steps every channel counter up toward its limit or down
// toward zero; mode 1 (evaluate) updates the qualified flags. A zero limit
// bypasses the counter: the raw pin (brake not inverted) or the ignition
// thresholds drive the flag directly.
// Result: flags are registered in the output register (skid if stalled).
// Throughput: one item per cycle while rsp_ready holds high; eight lanes
// update in parallel in the accept cycle, the result register plus a
// one-entry skid decouple req_ready from rsp_ready.
// Reset: counters, flags and buffers clear; limits 0, key-on 4095, key-off 0.
// Stall: with rsp stalled, one more item is taken into the skid register,
// then req_ready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_integrator_debounce_core (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  mcid_pkg::req_payload_type            req_data,
   // result channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output mcid_pkg::rsp_payload_type            rsp_data,
   // configuration channel
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [mcid_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire [mcid_pkg::LIMIT_BITS-1:0]       csr_wdata
);
   import mcid_pkg::*;

   logic [LIMIT_BITS-1:0]  limits_ff;
   logic [THRESH_BITS-1:0] key_on_ff, key_off_ff;

   logic                   accept;
   logic [THRESH_BITS-1:0] ign_level;
   logic                   ign_up, ign_down;
   logic [NUM_CH-1:0]      raw;      // raw pin per channel (ignition slot unused)
   logic [NUM_CH-1:0]      active;   // counting sense per channel
   lane_ctl_type           lane_ctl [NUM_CH];
   logic [NUM_CH-1:0]      flag_next;

   // --- CSR block ---------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff  <= '0;
         key_on_ff  <= KEY_ON_RESET;
         key_off_ff <= KEY_OFF_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LIMITS:  limits_ff  <= csr_wdata;
            CSR_KEY_ON:  key_on_ff  <= csr_wdata[THRESH_BITS-1:0];
            CSR_KEY_OFF: key_off_ff <= csr_wdata[THRESH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // --- input decode ------------------------------------------------------
   assign accept = req_valid && req_ready;

   // level = low ADC_BITS of the sample, times four
   assign ign_level = THRESH_BITS'({req_data.ign_sample[ADC_BITS-1:0], 2'b00});
   assign ign_up    = ign_level > key_on_ff;
   assign ign_down  = ign_level < key_off_ff;

   always_comb begin
      raw[CH_AC_REQ]   = req_data.ac_request_pin;
      raw[CH_AC_PRESS] = req_data.ac_pressure_pin;
      raw[CH_HEAD]     = req_data.head_lamp_pin;
      raw[CH_BRAKE]    = req_data.brake_pin;
      raw[CH_CRANK]    = req_data.crank_pin;
      raw[CH_CLUTCH]   = req_data.clutch_steer_pin;   // shared pin
      raw[CH_STEER]    = req_data.clutch_steer_pin;
      raw[CH_IGN]      = 1'b0;
      active           = raw;
      active[CH_BRAKE] = !req_data.brake_pin;         // brake is active low
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         lane_ctl[ch].count_en = accept && (req_data.mode == MODE_SAMPLE);
         lane_ctl[ch].eval_en  = accept && (req_data.mode == MODE_EVALUATE);
         if (ch == CH_IGN) begin
            // ignition holds in the dead band between the thresholds
            lane_ctl[ch].up   = ign_up;
            lane_ctl[ch].down = ign_down;
            lane_ctl[ch].set  = ign_up;
            lane_ctl[ch].clr  = ign_down;
         end else begin
            lane_ctl[ch].up   = active[ch];
            lane_ctl[ch].down = !active[ch];
            // bypass copies the raw pin, brake included without inversion
            lane_ctl[ch].set  = raw[ch];
            lane_ctl[ch].clr  = !raw[ch];
         end
      end
   end

   // --- channel lanes -----------------------------------------------------
   for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
      mcid_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (lane_ctl[g]),
         .limit     (limits_ff[8*g +: COUNT_BITS]),
         .flag_next (flag_next[g])
      );
   end

   // --- merge and output buffer -------------------------------------------
   mcid_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .flags     (flag_next),
      .in_ready  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
